[hdl/cosine_taylor_series_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion wrappers used by the output stage of the cosine series block.
// ----------------------------------------------------------------------------
`ifndef COSINE_TAYLOR_SERIES_MACROS_SVH
`define COSINE_TAYLOR_SERIES_MACROS_SVH

// check outside reset
`define CTS_CHECK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// check that also covers the reset cycles
`define CTS_CHECK_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/cts_pkg.sv]
// ----------------------------------------------------------------------------
// Cosine series package
// Widths, fixed-point constants and the lane type passed along the cell chain.
// ----------------------------------------------------------------------------
package cts_pkg;

  localparam int CTS_SERIES_TERMS = 16;

  localparam int ANGLE_W    = 32;
  localparam int COS_W      = 32;
  localparam int MAG_W      = 32;
  localparam int INV_PI_W   = 31;
  localparam int K_W        = 14;
  localparam int PI_W       = 34;
  localparam int KPI_W      = K_W + PI_W;
  localparam int FRAC_SHIFT = 16;
  localparam int K_SHIFT    = 48;
  localparam int X_W        = 32;
  localparam int X2_W       = 34;
  localparam int X2_SHIFT   = 30;
  localparam int LO_W       = 32;
  localparam int TERM_W     = 33;
  localparam int PROD_W     = 36;
  localparam int COEF_W     = 32;
  localparam int COEF_SHIFT = 32;
  localparam int SUM_W      = 35;

  localparam logic [INV_PI_W-1:0] INV_PI  = 31'd1367130574;
  localparam logic [PI_W-1:0]     PI_Q32  = 34'd13493037474;
  localparam logic [TERM_W-1:0]   TERM_ONE = 33'h0_4000_0000;
  localparam logic signed [SUM_W-1:0] SUM_ONE = 35'sh0_4000_0000;
  localparam logic signed [COS_W-1:0] COS_ONE = 32'sh4000_0000;

  typedef struct packed {
    logic                    vld;
    logic                    odd;
    logic [X2_W-1:0]         x2;
    logic [TERM_W-1:0]       term;
    logic signed [SUM_W-1:0] sum;
  } cts_lane_t;

endpackage

[hdl/cts_if.sv]
// ----------------------------------------------------------------------------
// Cosine series channels
// Valid/ready channels for the angle input and the cosine result.
// ----------------------------------------------------------------------------
interface cts_angle_if import cts_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] angle;

  modport source (output valid, output angle, input ready);
  modport sink   (input valid, input angle, output ready);
endinterface

interface cts_cosine_if import cts_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [COS_W-1:0] cosine;

  modport source (output valid, output cosine, input ready);
  modport sink   (input valid, input cosine, output ready);
endinterface

[hdl/cts_reduce.sv]
// ----------------------------------------------------------------------------
// Range reduction
// Removes whole multiples of pi from the angle magnitude and forms x squared.
// ----------------------------------------------------------------------------
module cts_reduce import cts_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  cts_angle_if.sink angle_ch,
  output cts_lane_t lane
);

  localparam int RABS_SHIFT = 2;

  logic [ANGLE_W-1:0]        raw;
  logic [MAG_W-1:0]          mag_in;
  logic [MAG_W-1:0]          mag1;
  logic [MAG_W-1:0]          mag2;
  logic [MAG_W-1:0]          mag3;
  logic [MAG_W+INV_PI_W-1:0] kprod;
  logic [K_W-1:0]            k2;
  logic [KPI_W-1:0]          kpi3;
  logic [KPI_W-1:0]          scaled;
  logic [KPI_W-1:0]          rabs;
  logic [X_W-1:0]            x4;
  logic [2*X_W-1:0]          xsq;
  logic [X2_W-1:0]           x2_5;
  logic                      odd3;
  logic                      odd4;
  logic                      odd5;
  logic                      v1;
  logic                      v2;
  logic                      v3;
  logic                      v4;
  logic                      v5;

  assign angle_ch.ready = en;
  assign raw    = angle_ch.angle;
  assign mag_in = raw[ANGLE_W-1] ? MAG_W'(~raw + 1'b1) : MAG_W'(raw);
  assign kprod  = mag1 * INV_PI;
  assign scaled = KPI_W'({mag3, {FRAC_SHIFT{1'b0}}});
  assign rabs   = (scaled >= kpi3) ? (scaled - kpi3) : (kpi3 - scaled);
  assign xsq    = x4 * x4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= angle_ch.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag1 <= mag_in;
      mag2 <= mag1;
      k2   <= kprod[K_SHIFT +: K_W];
      mag3 <= mag2;
      kpi3 <= k2 * PI_Q32;
      odd3 <= k2[0];
      x4   <= rabs[RABS_SHIFT +: X_W];
      odd4 <= odd3;
      x2_5 <= xsq[X2_SHIFT +: X2_W];
      odd5 <= odd4;
    end
  end

  always_comb begin
    lane.vld  = v5;
    lane.odd  = odd5;
    lane.x2   = x2_5;
    lane.term = TERM_ONE;
    lane.sum  = SUM_ONE;
  end

endmodule

[hdl/cts_cell.sv]
// ----------------------------------------------------------------------------
// Series cell
// Forms the next Taylor term from the previous one and adds it to, or for an odd index subtracts it from, the sum.
// ----------------------------------------------------------------------------
module cts_cell import cts_pkg::*; #(
  parameter int IDX = 1
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  cts_lane_t lane_in,
  output cts_lane_t lane_out
);

  localparam int DIV    = (2 * IDX) * (2 * IDX - 1);
  localparam int HP_W   = X2_W + 1;
  localparam int PH_W   = PROD_W - LO_W;
  localparam int FULL1_W = LO_W + HP_W;
  localparam int FULL2_W = LO_W + PH_W + COEF_W;
  localparam logic [COEF_W:0]   NUMER = {1'b1, {COEF_W{1'b0}}};
  localparam logic [COEF_W-1:0] COEF  = COEF_W'(NUMER / (COEF_W + 1)'(DIV));
  localparam bit SUBTRACT = (IDX % 2) == 1;

  cts_lane_t               ln1;
  cts_lane_t               ln2;
  cts_lane_t               ln3;
  cts_lane_t               ln4;
  cts_lane_t               ln5;
  cts_lane_t               ln5_next;
  logic [HP_W-1:0]         hp_in;
  logic [2*LO_W-1:0]       ll1;
  logic [HP_W-1:0]         hp1;
  logic [FULL1_W-1:0]      full1;
  logic [PROD_W-1:0]       p2;
  logic [2*LO_W-1:0]       pl3;
  logic [PH_W+COEF_W-1:0]  ph3;
  logic [FULL2_W-1:0]      full2;
  logic [TERM_W-1:0]       term4;
  logic signed [SUM_W-1:0] term_s;
  logic signed [SUM_W-1:0] sum_next;

  // high partial products of term times x squared, both weighted by 2^32
  assign hp_in = (lane_in.term[TERM_W-1] ? HP_W'(lane_in.x2) : HP_W'(0))
               + HP_W'(lane_in.term[LO_W-1:0] * lane_in.x2[X2_W-1:LO_W]);
  assign full1 = {hp1, LO_W'(0)} + FULL1_W'(ll1);
  assign full2 = {ph3, LO_W'(0)} + FULL2_W'(pl3);
  assign term_s = $signed(SUM_W'(term4));
  assign sum_next = SUBTRACT ? (ln4.sum - term_s) : (ln4.sum + term_s);

  always_comb begin
    ln5_next      = ln4;
    ln5_next.term = term4;
    ln5_next.sum  = sum_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ln1.vld <= 1'b0;
      ln2.vld <= 1'b0;
      ln3.vld <= 1'b0;
      ln4.vld <= 1'b0;
      ln5.vld <= 1'b0;
    end else if (en) begin
      ln1   <= lane_in;
      ll1   <= lane_in.term[LO_W-1:0] * lane_in.x2[LO_W-1:0];
      hp1   <= hp_in;
      ln2   <= ln1;
      p2    <= full1[X2_SHIFT +: PROD_W];
      ln3   <= ln2;
      pl3   <= p2[LO_W-1:0] * COEF;
      ph3   <= p2[PROD_W-1:LO_W] * COEF;
      ln4   <= ln3;
      term4 <= full2[COEF_SHIFT +: TERM_W];
      ln5   <= ln5_next;
    end
  end

  assign lane_out = ln5;

endmodule

[hdl/cts_outbuf.sv]
// ----------------------------------------------------------------------------
// Output stage
// Applies the sign of the odd multiple, saturates and buffers the result.
// ----------------------------------------------------------------------------
`include "cosine_taylor_series_macros.svh"

module cts_outbuf import cts_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  cts_lane_t     lane,
  output logic          en,
  cts_cosine_if.source  cosine_ch
);

  logic signed [SUM_W-1:0] sat;
  logic signed [SUM_W-1:0] res;
  logic                    fin_v;
  logic signed [COS_W-1:0] fin_d;
  logic                    ov;
  logic signed [COS_W-1:0] od;
  logic                    sv;
  logic signed [COS_W-1:0] sd;
  logic                    pop;
  logic                    push;

  // clamp is symmetric, so clamping before the negation gives the same value
  always_comb begin
    priority if (lane.sum > SUM_ONE) begin
      sat = SUM_ONE;
    end else if (lane.sum < -SUM_ONE) begin
      sat = -SUM_ONE;
    end else begin
      sat = lane.sum;
    end
    res = lane.odd ? -sat : sat;
  end

  assign en   = !sv;
  assign pop  = ov && cosine_ch.ready;
  assign push = en && fin_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_v <= 1'b0;
      ov    <= 1'b0;
      sv    <= 1'b0;
    end else begin
      if (en) begin
        fin_v <= lane.vld;
      end
      if (pop || !ov) begin
        if (sv) begin
          ov <= 1'b1;
          sv <= 1'b0;
        end else begin
          ov <= push;
        end
      end else if (push) begin
        sv <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_d <= res[COS_W-1:0];
    end
    if (pop || !ov) begin
      if (sv) begin
        od <= sd;
      end else if (push) begin
        od <= fin_d;
      end
    end else if (push) begin
      sd <= fin_d;
    end
  end

  assign cosine_ch.valid  = ov;
  assign cosine_ch.cosine = od;

  `CTS_CHECK_RST(a_reset_clears, rst |=> !ov && !sv, "output buffer not empty after reset")
  `CTS_CHECK(a_skid_behind_out, sv |-> ov, "skid item held with empty output register")
  `CTS_CHECK(a_skid_drain, sv && cosine_ch.ready |=> ov && od == $past(sd), "skid item lost")
  `CTS_CHECK(a_skid_fill, ov && !cosine_ch.ready && push |=> sv && sd == $past(fin_d), "stalled item dropped")
  `CTS_CHECK(a_range, ov |-> od <= COS_ONE && od >= -COS_ONE, "cosine outside saturation range")

endmodule

[hdl/cosine_taylor_series.sv]
// Throughput: one item per cycle while the output buffer is not full; every series cell is a five-stage pipeline whose
//   two split multiplies take a new item each cycle.
// Stalls: a two-entry output buffer holds results; the input stalls only when both are full.
// Reset: clears the valid bits of the pipeline and the output buffer; no clearing pass.
// ----------------------------------------------------------------------------
// Cosine by Taylor series
// Range reduction, a chain of series cells and a saturating output stage.
// ----------------------------------------------------------------------------
module cosine_taylor_series import cts_pkg::*; #(
  parameter int SERIES_TERMS = CTS_SERIES_TERMS
) (
  input  logic         clk,
  input  logic         rst,
  cts_angle_if.sink    angle_ch,
  cts_cosine_if.source cosine_ch
);

  logic      en;
  cts_lane_t chain [SERIES_TERMS+1];

  cts_reduce u_reduce (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .angle_ch (angle_ch),
    .lane     (chain[0])
  );

  for (genvar g = 0; g < SERIES_TERMS; g++) begin : g_cell
    cts_cell #(
      .IDX (g + 1)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .lane_in  (chain[g]),
      .lane_out (chain[g+1])
    );
  end

  cts_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .lane      (chain[SERIES_TERMS]),
    .en        (en),
    .cosine_ch (cosine_ch)
  );

endmodule

[bench/cosine_taylor_series_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cosine series testbench
// Drives angles into the cosine block through its valid/ready channels and
// checks every cosine against a bit-exact fixed-point prediction. Covers
// field extremes, angles close to multiples of pi, random angles under
// several idling patterns, and a long receiver hold-off that fills the block.
// ----------------------------------------------------------------------------
module cosine_taylor_series_test;
  import cts_pkg::*;

  localparam real PI_Q16 = 205887.416;

  logic clk;
  logic rst;

  cts_angle_if  angle_ch ();
  cts_cosine_if cosine_ch ();

  cosine_taylor_series #(
    .SERIES_TERMS(CTS_SERIES_TERMS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .angle_ch (angle_ch),
    .cosine_ch(cosine_ch)
  );

  logic signed [COS_W-1:0] expected_cosines[$];
  int fail_count;
  int sender_idle_pct;
  int receiver_stall_pct;
  int hold_off_left;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic signed [COS_W-1:0] cosine_of(input logic signed [ANGLE_W-1:0] ang);
    logic [63:0]        mag;
    logic [63:0]        k;
    logic signed [63:0] rem;
    logic [63:0]        rabs;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        coef;
    logic [63:0]        d;
    logic signed [63:0] sum;
    logic [127:0]       prod;
    int                 i;
    mag  = ang[ANGLE_W-1] ? (64'h1_0000_0000 - {32'b0, ang}) : {32'b0, ang};
    k    = (mag * 64'd1367130574) >> 48;
    rem  = $signed(mag << 16) - $signed(k * 64'd13493037474);
    rabs = rem[63] ? 64'(-rem) : 64'(rem);
    x    = rabs >> 2;
    prod = {64'b0, x} * {64'b0, x};
    x2   = prod[93:30];
    term = 64'd1 << 30;
    sum  = 64'sd1 <<< 30;
    for (i = 1; i <= CTS_SERIES_TERMS; i++) begin
      d    = 64'(2 * i) * 64'(2 * i - 1);
      coef = (64'd1 << 32) / d;
      prod = {64'b0, term} * {64'b0, x2};
      term = prod[93:30];
      prod = {64'b0, term} * {64'b0, coef};
      term = prod[95:32];
      if (i % 2 == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (k[0]) begin
      sum = -sum;
    end
    if (sum > 64'sd1073741824) begin
      sum = 64'sd1073741824;
    end
    if (sum < -64'sd1073741824) begin
      sum = -64'sd1073741824;
    end
    return sum[COS_W-1:0];
  endfunction

  // record the expected cosine of every accepted angle
  always @(posedge clk) begin
    if (!rst && angle_ch.valid && angle_ch.ready) begin
      expected_cosines.push_back(cosine_of(angle_ch.angle));
    end
  end

  always @(posedge clk) begin
    logic signed [COS_W-1:0] want;
    if (!rst && cosine_ch.valid && cosine_ch.ready) begin
      if (expected_cosines.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("unexpected cosine item: got %0d", cosine_ch.cosine);
        end
      end else begin
        want = expected_cosines.pop_front();
        if (cosine_ch.cosine !== want) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("cosine mismatch: expected %0d got %0d", want, cosine_ch.cosine);
          end
        end
      end
    end
  end

  // receiver: long hold-off when requested, else random stalls
  initial begin
    cosine_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        cosine_ch.ready <= 1'b0;
        hold_off_left--;
      end else begin
        cosine_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("** cosine_taylor_series: FAILED **");
    $finish;
  end

  task automatic send_angle(input logic signed [ANGLE_W-1:0] a);
    while ($urandom_range(99) < sender_idle_pct) begin
      angle_ch.valid <= 1'b0;
      @(negedge clk);
    end
    angle_ch.valid <= 1'b1;
    angle_ch.angle <= a;
    do @(posedge clk); while (!angle_ch.ready);
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    while (expected_cosines.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic signed [ANGLE_W-1:0] near_pi_multiple(input int k, input int offset);
    int base;
    base = $rtoi(k * PI_Q16);
    return base + offset;
  endfunction

  function automatic logic signed [ANGLE_W-1:0] random_angle();
    logic signed [ANGLE_W-1:0] a;
    case ($urandom_range(3))
      0: a = $urandom;
      1: a = $signed($urandom_range(0, 823550)) - 411775;
      2: begin
        a = near_pi_multiple($urandom_range(0, 10000), $signed($urandom_range(0, 6)) - 3);
        if ($urandom_range(1)) begin
          a = -a;
        end
      end
      default: a = $signed($urandom) >>> $urandom_range(0, 15);
    endcase
    return a;
  endfunction

  task automatic test_directed_angles();
    int ks[3];
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    send_angle(32'sd0);
    send_angle(32'sd1);
    send_angle(-32'sd1);
    send_angle(32'sh7FFF_FFFF);
    send_angle(32'sh8000_0000);
    send_angle(32'sd65536);
    send_angle(-32'sd65536);
    send_angle(32'sd102944);
    send_angle(32'sd205887);
    send_angle(32'sd205888);
    send_angle(-32'sd205887);
    send_angle(32'sd411775);
    send_angle(32'sd411774);
    send_angle(32'sd617662);
    send_angle(32'sd617663);
    ks = '{1001, 10000, 10429};
    foreach (ks[j]) begin
      send_angle(near_pi_multiple(ks[j], -1));
      send_angle(-near_pi_multiple(ks[j], 1));
    end
    angle_ch.valid <= 1'b0;
    wait_for_results();
  endtask

  task automatic test_random_angles(input int count, input int idle_pct, input int stall_pct);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (count) send_angle(random_angle());
    angle_ch.valid <= 1'b0;
    wait_for_results();
  endtask

  // hold the receiver off while angles keep coming, then drain
  task automatic test_backpressure();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    @(posedge clk);
    hold_off_left = 400;
    @(negedge clk);
    repeat (300) send_angle(random_angle());
    angle_ch.valid <= 1'b0;
    wait_for_results();
  endtask

  initial begin
    fail_count         = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_off_left      = 0;
    angle_ch.valid     = 1'b0;
    angle_ch.angle     = '0;
    rst                = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_angles();
    test_random_angles(270, 0, 0);
    test_random_angles(270, 61, 0);
    test_random_angles(270, 0, 61);
    test_random_angles(270, 24, 24);
    test_backpressure();

    repeat (120) @(posedge clk);
    if (expected_cosines.size() != 0) begin
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("** cosine_taylor_series: PASSED **");
    end else begin
      $display("** cosine_taylor_series: FAILED **");
    end
    $finish;
  end

endmodule
